/* hdl/pnmg_pkg.sv */
// Shared types and constants of the netpbm-to-gray stream decoder.
// No dependencies; compiled first.
`default_nettype none

package pnmg_pkg;

	// Largest accepted image dimension; larger header values saturate one above
	localparam int MAX_DIM = 4096;

	// Request codes on the input channel
	localparam logic [1:0] REQ_DATA  = 2'd0;
	localparam logic [1:0] REQ_EOS   = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	// Format codes; bit 0 marks colour, bit 1 marks binary samples
	localparam logic [1:0] FMT_P2 = 2'd0;
	localparam logic [1:0] FMT_P3 = 2'd1;
	localparam logic [1:0] FMT_P5 = 2'd2;
	localparam logic [1:0] FMT_P6 = 2'd3;

	// Error codes reported in error transactions
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MAGIC    = 3'd1;
	localparam logic [2:0] ERR_NO_NUM   = 3'd2;
	localparam logic [2:0] ERR_DIMS     = 3'd3;
	localparam logic [2:0] ERR_MAXVAL   = 3'd4;
	localparam logic [2:0] ERR_TRUNC    = 3'd5;
	localparam logic [2:0] ERR_TOO_BIG  = 3'd6;

	// Characters the parser looks for
	localparam logic [7:0] CHR_P    = 8'h50;
	localparam logic [7:0] CHR_2    = 8'h32;
	localparam logic [7:0] CHR_3    = 8'h33;
	localparam logic [7:0] CHR_5    = 8'h35;
	localparam logic [7:0] CHR_6    = 8'h36;
	localparam logic [7:0] CHR_0    = 8'h30;
	localparam logic [7:0] CHR_HASH = 8'h23;
	localparam logic [7:0] CHR_LF   = 8'h0A;

	// Luma weights; the weighted sum is divided by 1000
	localparam int COEF_R = 299;
	localparam int COEF_G = 587;
	localparam int COEF_B = 114;

	// Divide by 1000 as multiply by ceil(2^36/1000) and shift; exact below 2^26
	localparam int         DIV_SHIFT = 36;
	localparam logic [26:0] DIV_RECIP = 27'd68719477;

	// One result as it travels from the parser to the conversion pipeline
	typedef struct packed {
		logic        kind;
		logic        color;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [11:0] row;
		logic [11:0] col;
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] maxval;
		logic [2:0]  err;
		logic        last;
	} pnmg_entry_t;

	// Zero, one or two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0]  n;
		pnmg_entry_t e0;
		pnmg_entry_t e1;
	} pnmg_push_t;

endpackage

`default_nettype wire

/* hdl/pnmg_if.sv */
// Valid/ready channel interfaces for the decoder's byte input and result output.
// No dependencies.
`default_nettype none

interface pnmg_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface pnmg_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  gray_pixel;
	logic [11:0] pixel_row;
	logic [11:0] pixel_col;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic [15:0] image_maxval;
	logic [2:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output gray_pixel, output pixel_row,
		output pixel_col, output image_width, output image_height, output image_maxval,
		output error_code, output last, input ready);
	modport sink (input valid, input kind, input gray_pixel, input pixel_row,
		input pixel_col, input image_width, input image_height, input image_maxval,
		input error_code, input last, output ready);
endinterface

`default_nettype wire

/* hdl/pnmg_front.sv */
// Front end: byte parser for magic, header, comments and samples; emits result entries.
// Depends on pnmg_pkg and pnmg_in_if.
`default_nettype none

module pnmg_front
	import pnmg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pnmg_in_if.sink    in_chan,
	input  wire logic  room,
	output pnmg_push_t push
);

	// Parse phases
	localparam logic [3:0] PH_MAGIC_P     = 4'd0;
	localparam logic [3:0] PH_MAGIC_DIGIT = 4'd1;
	localparam logic [3:0] PH_MAGIC_END   = 4'd2;
	localparam logic [3:0] PH_HEADER      = 4'd3;
	localparam logic [3:0] PH_SKIP        = 4'd4;
	localparam logic [3:0] PH_BIN         = 4'd5;
	localparam logic [3:0] PH_ASCII       = 4'd6;
	localparam logic [3:0] PH_DONE        = 4'd7;
	localparam logic [3:0] PH_HALT        = 4'd8;

	logic [3:0]  ph_q, n_ph;
	logic [1:0]  fmt_q, n_fmt;
	logic        cmt_q, n_cmt;
	logic [15:0] acc_q, n_acc;
	logic        hd_q, n_hd;
	logic [1:0]  fld_q, n_fld;
	logic [12:0] wid_q, n_wid;
	logic [12:0] hgt_q, n_hgt;
	logic [15:0] maxv_q, n_maxv;
	logic [11:0] row_q, n_row;
	logic [11:0] col_q, n_col;
	logic [15:0] red_q, n_red;
	logic [15:0] grn_q, n_grn;
	logic [1:0]  ch_q, n_ch;

	logic        take;
	logic [7:0]  b;
	logic        b_digit;
	logic        b_space;
	logic [19:0] acc10;
	logic [12:0] sat_v;
	logic        fin;
	logic        sep;
	logic        smp;
	logic [15:0] sval;
	logic        eos_chk;
	logic        err;
	logic [2:0]  ecode;
	logic        pix;
	logic        pix_color;
	logic        pix_last;
	logic [12:0] col_inc;

	pnmg_entry_t pe;
	pnmg_entry_t ee;

	assign in_chan.ready = room;
	assign take    = in_chan.valid && room;
	assign b       = in_chan.data_byte;
	assign b_digit = b inside {[8'h30:8'h39]};
	assign b_space = b inside {8'h20, [8'h09:8'h0D]};
	assign acc10   = 20'(acc_q) * 20'd10 + 20'(b - CHR_0);
	assign sat_v   = (acc_q > 16'(MAX_DIM)) ? 13'(MAX_DIM + 1) : acc_q[12:0];
	assign col_inc = {1'b0, col_q} + 13'd1;

	// Step the parser through one transaction
	always_comb begin
		n_ph = ph_q; n_fmt = fmt_q; n_cmt = cmt_q; n_acc = acc_q; n_hd = hd_q;
		n_fld = fld_q; n_wid = wid_q; n_hgt = hgt_q; n_maxv = maxv_q;
		n_row = row_q; n_col = col_q; n_red = red_q; n_grn = grn_q; n_ch = ch_q;
		fin = 1'b0; sep = 1'b0; smp = 1'b0; sval = '0; eos_chk = 1'b0;
		err = 1'b0; ecode = ERR_NONE;
		pix = 1'b0; pix_color = 1'b0; pix_last = 1'b0;

		// dispatch on request and phase
		if (take) begin
			case (in_chan.req_type)
				REQ_DATA: begin
					case (ph_q)
						PH_MAGIC_P: begin
							if (b == CHR_P) begin
								n_ph = PH_MAGIC_DIGIT;
							end else if (!b_space) begin
								err = 1'b1; ecode = ERR_MAGIC; n_ph = PH_HALT;
							end
						end
						PH_MAGIC_DIGIT: begin
							n_ph = PH_MAGIC_END;
							case (b)
								CHR_2: n_fmt = FMT_P2;
								CHR_3: n_fmt = FMT_P3;
								CHR_5: n_fmt = FMT_P5;
								CHR_6: n_fmt = FMT_P6;
								default: begin
									err = 1'b1; ecode = ERR_MAGIC; n_ph = PH_HALT;
								end
							endcase
						end
						PH_MAGIC_END: begin
							if (b_space) begin
								n_ph = PH_HEADER;
							end else begin
								err = 1'b1; ecode = ERR_MAGIC; n_ph = PH_HALT;
							end
						end
						PH_HEADER, PH_ASCII: begin
							if (!hd_q) begin
								sep = 1'b1;
							end else if (b_digit) begin
								if (acc10 > 20'd65535) begin
									err = 1'b1; ecode = ERR_TOO_BIG; n_ph = PH_HALT;
								end else begin
									n_acc = acc10[15:0];
								end
							end else begin
								fin = 1'b1;
							end
						end
						PH_SKIP: n_ph = PH_BIN;
						PH_BIN: begin
							smp = 1'b1; sval = {8'd0, b};
						end
						default: ;
					endcase
				end
				REQ_EOS: begin
					case (ph_q)
						PH_MAGIC_P, PH_MAGIC_DIGIT: begin
							err = 1'b1; ecode = ERR_MAGIC; n_ph = PH_HALT;
						end
						PH_MAGIC_END: begin
							err = 1'b1; ecode = ERR_NO_NUM; n_ph = PH_HALT;
						end
						PH_HEADER, PH_ASCII: begin
							fin = hd_q; eos_chk = 1'b1;
						end
						PH_SKIP, PH_BIN: begin
							err = 1'b1; ecode = ERR_TRUNC; n_ph = PH_HALT;
						end
						default: ;
					endcase
				end
				REQ_START: begin
					n_ph = PH_MAGIC_P; n_fmt = FMT_P2; n_cmt = 1'b0; n_acc = '0; n_hd = 1'b0;
					n_fld = '0; n_wid = '0; n_hgt = '0; n_maxv = '0;
					n_row = '0; n_col = '0; n_red = '0; n_grn = '0; n_ch = '0;
				end
				default: ;
			endcase
		end

		// finish the pending number
		if (fin) begin
			n_acc = '0;
			n_hd  = 1'b0;
			if (ph_q == PH_HEADER) begin
				case (fld_q)
					2'd0: begin
						n_wid = sat_v; n_fld = 2'd1;
					end
					2'd1: begin
						n_hgt = sat_v; n_fld = 2'd2;
					end
					default: begin
						n_maxv = acc_q; n_fld = 2'd3;
						if (wid_q == '0 || hgt_q == '0 || wid_q > 13'(MAX_DIM) ||
								hgt_q > 13'(MAX_DIM)) begin
							err = 1'b1; ecode = ERR_DIMS; n_ph = PH_HALT;
						end else begin
							n_row = '0; n_col = '0; n_ch = '0;
							n_ph  = fmt_q[1] ? PH_SKIP : PH_ASCII;
						end
					end
				endcase
			end else begin
				if (fmt_q == FMT_P2 && acc_q > maxv_q) begin
					err = 1'b1; ecode = ERR_MAXVAL; n_ph = PH_HALT;
				end else begin
					smp = 1'b1; sval = acc_q;
				end
			end
		end

		// take one sample: gray directly, colour after the third channel
		if (smp) begin
			if (!fmt_q[0]) begin
				pix = 1'b1;
			end else begin
				case (ch_q)
					2'd0: begin
						n_red = sval; n_ch = 2'd1;
					end
					2'd1: begin
						n_grn = sval; n_ch = 2'd2;
					end
					default: begin
						n_ch = 2'd0; pix = 1'b1; pix_color = 1'b1;
					end
				endcase
			end
			if (pix) begin
				pix_last = ({1'b0, row_q} + 13'd1 == hgt_q) && (col_inc == wid_q);
				if (pix_last) begin
					n_ph = PH_DONE;
				end else if (col_inc >= wid_q) begin
					n_col = '0;
					n_row = row_q + 12'd1;
				end else begin
					n_col = col_inc[11:0];
				end
			end
		end

		// the byte that ended a number: drop it before binary data, rescan it in the header or ASCII data
		if (fin && in_chan.req_type == REQ_DATA) begin
			if (n_ph == PH_SKIP) begin
				n_ph = PH_BIN;
			end else if (n_ph == PH_HEADER || n_ph == PH_ASCII) begin
				sep = 1'b1;
			end
		end

		// scan separators, comments and the first digit of a number
		if (sep) begin
			if (n_cmt) begin
				if (b == CHR_LF) n_cmt = 1'b0;
			end else if (b == CHR_HASH) begin
				n_cmt = 1'b1;
			end else if (b_digit) begin
				n_acc = 16'(b - CHR_0);
				n_hd  = 1'b1;
			end else if (!b_space) begin
				err = 1'b1; ecode = ERR_NO_NUM; n_ph = PH_HALT;
			end
		end

		// end of stream inside the header or ASCII data
		if (eos_chk) begin
			if (n_ph == PH_HEADER || n_ph == PH_ASCII) begin
				err = 1'b1; ecode = ERR_NO_NUM;
			end else if (n_ph == PH_SKIP || n_ph == PH_BIN) begin
				err = 1'b1; ecode = ERR_TRUNC;
			end
		end
		if (take && in_chan.req_type == REQ_EOS) begin
			n_ph = PH_HALT; n_cmt = 1'b0; n_hd = 1'b0; n_acc = '0;
		end
	end

	// Build the result entries; header fields show their values after this step
	always_comb begin
		pe        = '0;
		pe.kind   = 1'b0;
		pe.color  = pix_color;
		pe.red    = red_q;
		pe.green  = grn_q;
		pe.blue   = sval;
		pe.row    = row_q;
		pe.col    = col_q;
		pe.width  = n_wid;
		pe.height = n_hgt;
		pe.maxval = n_maxv;
		pe.err    = ERR_NONE;
		pe.last   = pix_last;

		ee        = '0;
		ee.kind   = 1'b1;
		ee.width  = n_wid;
		ee.height = n_hgt;
		ee.maxval = n_maxv;
		ee.err    = ecode;

		push.n  = 2'(pix) + 2'(err);
		push.e0 = pix ? pe : ee;
		push.e1 = ee;
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_MAGIC_P; fmt_q <= FMT_P2; cmt_q <= 1'b0; acc_q <= '0; hd_q <= 1'b0;
			fld_q <= '0; wid_q <= '0; hgt_q <= '0; maxv_q <= '0;
			row_q <= '0; col_q <= '0; red_q <= '0; grn_q <= '0; ch_q <= '0;
		end else if (take) begin
			ph_q <= n_ph; fmt_q <= n_fmt; cmt_q <= n_cmt; acc_q <= n_acc; hd_q <= n_hd;
			fld_q <= n_fld; wid_q <= n_wid; hgt_q <= n_hgt; maxv_q <= n_maxv;
			row_q <= n_row; col_q <= n_col; red_q <= n_red; grn_q <= n_grn; ch_q <= n_ch;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> !push.e0.kind && push.e1.kind)
		else $error("two results in one step must be pixel then error");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2 || (push.n == 2'd1 && push.e0.kind)) |=> ph_q == PH_HALT)
		else $error("parser kept running after an error");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0 && !push.e0.kind) |-> {1'b0, push.e0.col} < push.e0.width)
		else $error("pixel column outside the image width");

endmodule

`default_nettype wire

/* hdl/pnmg_queue.sv */
// Small result queue between parser and conversion pipeline; up to two writes a cycle.
// Depends on pnmg_pkg.
`default_nettype none

module pnmg_queue
	import pnmg_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pnmg_push_t  push,
	input  wire logic        pop,
	output pnmg_entry_t      head,
	output logic             head_valid,
	output logic             room
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pnmg_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr1;
	logic [PW-1:0] wr2;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr1        = nxt(wr_q);
	assign wr2        = nxt(wr1);
	assign head       = mem_q[rd_q];
	assign head_valid = (cnt_q != '0);
	assign room       = (cnt_q <= CW'(DEPTH - 2));

	// Write entries
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.e0;
		if (push.n == 2'd2) mem_q[wr1] <= push.e1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.n == 2'd1) wr_q <= wr1;
			else if (push.n == 2'd2) wr_q <= wr2;
			if (pop) rd_q <= nxt(rd_q);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty result queue");

endmodule

`default_nettype wire

/* hdl/pnmg_back.sv */
// Back end: colour-to-gray conversion pipeline and output register.
// Depends on pnmg_pkg and pnmg_out_if.
`default_nettype none

module pnmg_back
	import pnmg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pnmg_entry_t head,
	input  wire logic        head_valid,
	output logic             pop,
	pnmg_out_if.source       out_chan
);

	logic        adv;
	logic        v_s1, v_s2, v_s3;
	pnmg_entry_t e_s1, e_s2, e_s3;
	logic [24:0] pr_s1;
	logic [25:0] pg_s1;
	logic [22:0] pb_s1;
	logic [25:0] sum_s2;
	logic [7:0]  gray_s3;
	logic [52:0] recip_prod;

	// Move the whole pipeline when the output slot is free or being taken
	assign adv = !v_s3 || out_chan.ready;
	assign pop = adv && head_valid;

	assign recip_prod = 53'(sum_s2) * 53'(DIV_RECIP);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Weighted channels, weighted sum, then divide by 1000; gray samples pass straight through
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1    <= head;
			pr_s1   <= 25'(head.red) * 25'(COEF_R);
			pg_s1   <= 26'(head.green) * 26'(COEF_G);
			pb_s1   <= 23'(head.blue) * 23'(COEF_B);
			e_s2    <= e_s1;
			sum_s2  <= 26'(pr_s1) + pg_s1 + 26'(pb_s1);
			e_s3    <= e_s2;
			gray_s3 <= e_s2.color ? recip_prod[DIV_SHIFT +: 8] : e_s2.blue[7:0];
		end
	end

	assign out_chan.valid        = v_s3;
	assign out_chan.kind         = e_s3.kind;
	assign out_chan.gray_pixel   = gray_s3;
	assign out_chan.pixel_row    = e_s3.row;
	assign out_chan.pixel_col    = e_s3.col;
	assign out_chan.image_width  = e_s3.width;
	assign out_chan.image_height = e_s3.height;
	assign out_chan.image_maxval = e_s3.maxval;
	assign out_chan.error_code   = e_s3.err;
	assign out_chan.last         = e_s3.last;

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_chan.valid && out_chan.kind) |->
			out_chan.gray_pixel == 8'd0 && !out_chan.last && out_chan.error_code != ERR_NONE)
		else $error("error transaction carries pixel data");

endmodule

`default_nettype wire

/* hdl/pnm_stream_to_gray_decoder_core.sv */
// Top level of the netpbm (P2/P3/P5/P6) to gray pixel stream decoder.
// Depends on pnmg_pkg, pnmg_if, pnmg_front, pnmg_queue and pnmg_back.
//
// The decoder takes one transaction per clock on in_chan, unless in_chan.ready is low:
// a file byte, an end of stream or a start of a new file. The parser reads the header
// (magic, width, height, maxval, with comments) and the samples in the same cycle as the
// byte arrives and writes its results into a queue of QUEUE_DEPTH entries; in_chan.ready
// is high while the queue has room for two, so it only drops when out_chan is stalled.
// A three-stage pipeline turns colour triples into gray ((299R+587G+114B)/1000 by
// reciprocal multiplication) and presents one result per clock on out_chan while
// out_chan.ready is high. Most transactions give no result or one; an end of stream that
// completes a pending ASCII pixel other than the image's last gives a pixel followed by
// an error report. After an error, bytes are ignored until a start request.
`default_nettype none

module pnm_stream_to_gray_decoder_core
	import pnmg_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pnmg_in_if.sink   in_chan,
	pnmg_out_if.source out_chan
);

	pnmg_push_t  push;
	pnmg_entry_t head;
	logic        head_valid;
	logic        room;
	logic        pop;

	pnmg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_chan),
		.room    (room),
		.push    (push)
	);

	pnmg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room       (room)
	);

	pnmg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_chan   (out_chan)
	);

endmodule

`default_nettype wire

/* bench/pnm_stream_to_gray_decoder_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the netpbm-to-gray stream decoder: directed headers,
// output stall pressure and random P2/P3/P5/P6 files with errors injected.
// Depends on pnmg_pkg, pnmg_if and the decoder RTL.

module pnm_stream_to_gray_decoder_core_tb;
	import pnmg_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// Parser position inside one file
	typedef enum int {
		S_WANT_P, S_WANT_DIGIT, S_WANT_SPACE, S_HEADER, S_DROP, S_RAW, S_TEXT,
		S_DONE, S_HALT
	} parse_step_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  gray;
		logic [11:0] row;
		logic [11:0] col;
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] maxval;
		logic [2:0]  err;
		logic        last;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pnmg_in_if  in_if ();
	pnmg_out_if out_if ();

	pnm_stream_to_gray_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_chan  (in_if),
		.out_chan (out_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Decoder state mirrored by the bench
	parse_step_t st;
	logic [1:0]  fmt;
	bit          in_cmt, have_dig;
	int          acc, fld, img_w, img_h, img_max;
	int          row_i, col_i, red_v, grn_v, chan_i;
	int          n_new;

	pix_result_t decoded_q[$];
	logic [7:0]  file_q[$];

	int fail_cnt = 0;
	int accepted_cnt = 0;
	int hold_len = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	//------------------------------------------------------------------
	// Decode predictor
	//------------------------------------------------------------------

	function automatic void decoder_clear();
		st = S_WANT_P;
		fmt = FMT_P2;
		in_cmt = 0;
		acc = 0;
		have_dig = 0;
		fld = 0;
		img_w = 0;
		img_h = 0;
		img_max = 0;
		row_i = 0;
		col_i = 0;
		red_v = 0;
		grn_v = 0;
		chan_i = 0;
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= CHR_0 && b <= CHR_0 + 8'd9;
	endfunction

	function automatic bit is_ws(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// Queue one result; at most two per transaction
	function automatic void push_result(bit k, int g, int r, int c, logic [2:0] e, bit l);
		pix_result_t x;
		if (n_new >= 2) return;
		x.kind = k;
		x.gray = g[7:0];
		x.row = r[11:0];
		x.col = c[11:0];
		x.width = img_w[12:0];
		x.height = img_h[12:0];
		x.maxval = img_max[15:0];
		x.err = e;
		x.last = l;
		decoded_q.push_back(x);
		n_new++;
	endfunction

	function automatic void report_error(logic [2:0] code);
		push_result(1'b1, 0, 0, 0, code, 1'b0);
		st = S_HALT;
	endfunction

	function automatic void emit_gray(int g);
		bit lst;
		lst = (row_i + 1 == img_h) && (col_i + 1 == img_w);
		push_result(1'b0, g, row_i, col_i, ERR_NONE, lst);
		if (lst) begin
			st = S_DONE;
			return;
		end
		col_i++;
		if (col_i >= img_w) begin
			col_i = 0;
			row_i++;
		end
	endfunction

	// Gray samples go straight out; colour samples gather into a triple
	function automatic void take_sample(int v);
		if (!fmt[0]) begin
			emit_gray(v);
			return;
		end
		if (chan_i == 0) begin
			red_v = v;
			chan_i = 1;
		end else if (chan_i == 1) begin
			grn_v = v;
			chan_i = 2;
		end else begin
			chan_i = 0;
			emit_gray((COEF_R * red_v + COEF_G * grn_v + COEF_B * v) / 1000);
		end
	endfunction

	function automatic int clamp_dim(int v);
		return v > MAX_DIM ? MAX_DIM + 1 : v;
	endfunction

	// Store a finished number as a header field or a text sample
	function automatic void close_number();
		int v;
		v = acc;
		acc = 0;
		have_dig = 0;
		if (st == S_HEADER) begin
			case (fld)
				0: begin
					img_w = clamp_dim(v);
					fld = 1;
				end
				1: begin
					img_h = clamp_dim(v);
					fld = 2;
				end
				default: begin
					img_max = v;
					fld = 3;
					if (img_w == 0 || img_h == 0 || img_w > MAX_DIM || img_h > MAX_DIM) begin
						report_error(ERR_DIMS);
						return;
					end
					row_i = 0;
					col_i = 0;
					chan_i = 0;
					st = fmt[1] ? S_DROP : S_TEXT;
				end
			endcase
		end else if (st == S_TEXT) begin
			if (fmt == FMT_P2 && v > img_max) begin
				report_error(ERR_MAXVAL);
				return;
			end
			take_sample(v);
		end
	endfunction

	function automatic void scan_sep(logic [7:0] b);
		if (in_cmt) begin
			if (b == CHR_LF) in_cmt = 0;
		end else if (b == CHR_HASH) begin
			in_cmt = 1;
		end else if (is_digit(b)) begin
			acc = b - CHR_0;
			have_dig = 1;
		end else if (!is_ws(b)) begin
			report_error(ERR_NO_NUM);
		end
	endfunction

	function automatic void number_in(logic [7:0] b);
		int v;
		if (!have_dig) begin
			scan_sep(b);
			return;
		end
		if (is_digit(b)) begin
			v = acc * 10 + (b - CHR_0);
			if (v > 65535) report_error(ERR_TOO_BIG);
			else acc = v;
			return;
		end
		close_number();
		// the byte that ends a binary maxval is the dropped one
		if (st == S_DROP) begin
			st = S_RAW;
			return;
		end
		if (st == S_HEADER || st == S_TEXT) scan_sep(b);
	endfunction

	function automatic void data_in(logic [7:0] b);
		case (st)
			S_WANT_P: begin
				if (b == CHR_P) st = S_WANT_DIGIT;
				else if (!is_ws(b)) report_error(ERR_MAGIC);
			end
			S_WANT_DIGIT: begin
				if (b == CHR_2) fmt = FMT_P2;
				else if (b == CHR_3) fmt = FMT_P3;
				else if (b == CHR_5) fmt = FMT_P5;
				else if (b == CHR_6) fmt = FMT_P6;
				else begin
					report_error(ERR_MAGIC);
					return;
				end
				st = S_WANT_SPACE;
			end
			S_WANT_SPACE: begin
				if (is_ws(b)) st = S_HEADER;
				else report_error(ERR_MAGIC);
			end
			S_HEADER, S_TEXT: number_in(b);
			S_DROP: st = S_RAW;
			S_RAW: take_sample(b);
			default: ;
		endcase
	endfunction

	function automatic void stream_end();
		case (st)
			S_WANT_P, S_WANT_DIGIT: report_error(ERR_MAGIC);
			S_WANT_SPACE: report_error(ERR_NO_NUM);
			S_HEADER, S_TEXT: begin
				// complete a pending number first
				if (have_dig) close_number();
				if (st == S_HEADER || st == S_TEXT) report_error(ERR_NO_NUM);
				else if (st == S_DROP || st == S_RAW) report_error(ERR_TRUNC);
			end
			S_DROP, S_RAW: report_error(ERR_TRUNC);
			default: ;
		endcase
		st = S_HALT;
		in_cmt = 0;
		have_dig = 0;
		acc = 0;
	endfunction

	function automatic void predict_decode(logic [1:0] req, logic [7:0] b);
		n_new = 0;
		if (req == REQ_DATA) data_in(b);
		else if (req == REQ_EOS) stream_end();
		else if (req == REQ_START) decoder_clear();
	endfunction

	//------------------------------------------------------------------
	// Input side
	//------------------------------------------------------------------

	// Offer one transaction after a random gap and predict on acceptance
	task automatic send_req(input logic [1:0] req, input logic [7:0] b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.req_type <= req;
		in_if.data_byte <= b;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		accepted_cnt++;
		predict_decode(req, b);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_req(REQ_DATA, s[i]);
	endtask

	// Drop valid and hold until every predicted result has been taken
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		do @(posedge clk); while (decoded_q.size() != 0);
	endtask

	//------------------------------------------------------------------
	// Output side
	//------------------------------------------------------------------

	task automatic check_result(input pix_result_t got);
		pix_result_t want;
		if (decoded_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("unexpected result: kind=%0d gray=%0d err=%0d", got.kind, got.gray,
					got.err);
			return;
		end
		want = decoded_q.pop_front();
		if (got !== want) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS) begin
				$display("mismatch want: kind=%0d gray=%0d row=%0d col=%0d last=%0d",
					want.kind, want.gray, want.row, want.col, want.last);
				$display("               w=%0d h=%0d max=%0d err=%0d",
					want.width, want.height, want.maxval, want.err);
				$display("          got: kind=%0d gray=%0d row=%0d col=%0d last=%0d",
					got.kind, got.gray, got.row, got.col, got.last);
				$display("               w=%0d h=%0d max=%0d err=%0d",
					got.width, got.height, got.maxval, got.err);
			end
		end
	endtask

	// Take results with random stalls and an occasional long hold-off
	initial begin : result_sink
		pix_result_t got;
		int stall;
		out_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				out_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = rx_idle_en ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (out_if.valid !== 1'b1);
			got.kind = out_if.kind;
			got.gray = out_if.gray_pixel;
			got.row = out_if.pixel_row;
			got.col = out_if.pixel_col;
			got.width = out_if.image_width;
			got.height = out_if.image_height;
			got.maxval = out_if.image_maxval;
			got.err = out_if.error_code;
			got.last = out_if.last;
			check_result(got);
		end
	end

	//------------------------------------------------------------------
	// Random file construction
	//------------------------------------------------------------------

	function automatic logic [7:0] ws_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0: c = 8'h09;
			1: c = 8'h0A;
			2: c = 8'h0B;
			3: c = 8'h0C;
			4: c = 8'h0D;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

	// Whitespace, sometimes with a comment running to the next newline
	function automatic void push_gap();
		int n;
		logic [7:0] c;
		n = $urandom_range(1, 2);
		repeat (n) file_q.push_back(ws_char());
		if ($urandom_range(0, 6) == 0) begin
			file_q.push_back(CHR_HASH);
			n = $urandom_range(0, 4);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				if (c == CHR_LF) c = 8'h00;
				file_q.push_back(c);
			end
			file_q.push_back(CHR_LF);
			if ($urandom_range(0, 1)) file_q.push_back(ws_char());
		end
	endfunction

	function automatic void push_num(int v);
		string s;
		int i, z;
		z = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
		repeat (z) file_q.push_back(CHR_0);
		s = $sformatf("%0d", v);
		for (i = 0; i < s.len(); i++) file_q.push_back(s[i]);
	endfunction

	function automatic int dim_pick();
		int d;
		case ($urandom_range(0, 6))
			0: d = 0;
			1: d = MAX_DIM;
			2: d = MAX_DIM + 1;
			3: d = 65535;
			4: d = 65536;
			5: d = 1;
			default: d = $urandom_range(1, 3);
		endcase
		return d;
	endfunction

	function automatic int text_sample(logic [1:0] f, int mv, bit wild);
		int r;
		r = $urandom_range(0, 99);
		if (f == FMT_P2) begin
			if (!wild || r < 85) return $urandom_range(0, mv);
			if (r < 95) return mv + 1 + $urandom_range(0, 3);
			return $urandom_range(65536, 99999);
		end
		if (r < 70) return $urandom_range(0, 255);
		if (!wild || r < 95) return $urandom_range(0, 65535);
		return $urandom_range(65536, 99999);
	endfunction

	// Build one file, mostly well formed, then break some and send it
	task automatic random_file();
		logic [1:0] f;
		logic [7:0] c;
		int w, h, mv, ch, nsamp, r, pos, i;
		bit wild, eos;
		int ends_q[$];
		file_q.delete();
		f = 2'($urandom_range(0, 3));
		ch = f[0] ? 3 : 1;
		wild = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 99);
		if (r < 75) begin
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 4);
		end else if (r < 87) begin
			w = $urandom_range(1, 16);
			h = (w > 3) ? 1 : $urandom_range(5, 16);
		end else begin
			w = dim_pick();
			h = dim_pick();
		end
		r = $urandom_range(0, 99);
		if (r < 55) mv = $urandom_range(1, 255);
		else if (r < 70) mv = 255;
		else if (r < 82) mv = 65535;
		else if (r < 90) mv = 0;
		else mv = $urandom_range(256, 65534);

		// magic and header
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) file_q.push_back(ws_char());
		file_q.push_back(CHR_P);
		case (f)
			FMT_P2: c = CHR_2;
			FMT_P3: c = CHR_3;
			FMT_P5: c = CHR_5;
			default: c = CHR_6;
		endcase
		file_q.push_back(c);
		file_q.push_back(ws_char());
		if ($urandom_range(0, 1)) push_gap();
		push_num(w);
		push_gap();
		push_num(h);
		push_gap();
		push_num(mv);
		if (f[1]) begin
			if ($urandom_range(0, 4) == 0) begin
				do c = 8'($urandom_range(0, 255)); while (is_digit(c));
			end else begin
				c = ws_char();
			end
			file_q.push_back(c);
		end else begin
			push_gap();
		end

		// samples
		nsamp = (w <= 16 && h <= 16) ? w * h * ch : $urandom_range(0, 12);
		for (i = 0; i < nsamp; i++) begin
			if (f[1]) begin
				file_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				push_num(text_sample(f, mv, wild));
				ends_q.push_back(file_q.size());
				if (i < nsamp - 1 || $urandom_range(0, 1)) push_gap();
			end
		end

		// ending: clean, trailing bytes, truncation or a corrupted byte
		eos = 0;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			eos = 1;
		end else if (r < 65) begin
			repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
		end else if (r >= 80 && r < 92) begin
			if (!f[1] && ends_q.size() > 0 && $urandom_range(0, 1))
				pos = ends_q[$urandom_range(0, ends_q.size() - 1)];
			else
				pos = $urandom_range(0, file_q.size() - 1);
			while (file_q.size() > pos) file_q.delete(file_q.size() - 1);
			eos = 1;
		end else if (r >= 92) begin
			file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
			eos = 1'($urandom_range(0, 1));
		end

		tx_idle_en = ($urandom_range(0, 4) != 0);
		rx_idle_en = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 9) == 0) wait_drained();
		if ($urandom_range(0, 19) != 0) send_req(REQ_START, 8'($urandom_range(0, 255)));
		for (i = 0; i < file_q.size(); i++) begin
			if ($urandom_range(0, 49) == 0) send_req(REQ_NONE, 8'($urandom_range(0, 255)));
			send_req(REQ_DATA, file_q[i]);
		end
		if (eos) send_req(REQ_EOS, 8'($urandom_range(0, 255)));
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	// Ignored request, magic errors and a one-pixel binary colour file cut off after one byte
	task automatic test_directed();
		send_req(REQ_NONE, 8'hA5);
		send_req(REQ_START, 8'h00);
		send_req(REQ_DATA, 8'h20);
		send_req(REQ_DATA, "Q");
		send_req(REQ_START, 8'hFF);
		send_text("P6 1 1 255\n");
		send_req(REQ_DATA, 8'hFF);
		send_req(REQ_START, 8'h00);
		send_req(REQ_DATA, CHR_P);
		send_req(REQ_EOS, 8'h00);
		send_req(REQ_START, 8'h00);
		send_text("P3");
		send_req(REQ_EOS, 8'hFF);
	endtask

	// Hold the output off while bytes keep coming so the input stalls
	task automatic test_backpressure();
		int i;
		tx_idle_en = 0;
		rx_idle_en = 1;
		send_req(REQ_START, 8'h00);
		send_text("P5 8 8 255\n");
		hold_len = 250;
		for (i = 0; i < 64; i++) send_req(REQ_DATA, 8'($urandom_range(0, 255)));
		wait_drained();
		tx_idle_en = 1;
	endtask

	task automatic test_random_files(input int n);
		int goal;
		goal = accepted_cnt + n;
		while (accepted_cnt < goal) random_file();
	endtask

	initial begin : stimulus
		in_if.valid = 1'b0;
		in_if.req_type = REQ_DATA;
		in_if.data_byte = 8'h00;
		arst_n = 1'b0;
		decoder_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_files(1800);
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && decoded_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// End a hung run
	initial begin : watchdog
		int cyc;
		for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/pnmg_pkg.sv
hdl/pnmg_if.sv
hdl/pnmg_front.sv
hdl/pnmg_queue.sv
hdl/pnmg_back.sv
hdl/pnm_stream_to_gray_decoder_core.sv
bench/pnm_stream_to_gray_decoder_core_tb.sv
